// File: sv/siphash_pkg.sv
// ----------------------------------------------------------------------------
// siphash_pkg
// Constants, register indexes and the shared half-round function for the
// SipHash keyed hash block.
// ----------------------------------------------------------------------------
package siphash_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_ROUNDS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIN_ROUNDS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_OUTPUT = 3'd4;

  // initial lane constants
  localparam logic [63:0] IV0 = 64'h736f6d6570736575;
  localparam logic [63:0] IV1 = 64'h646f72616e646f6d;
  localparam logic [63:0] IV2 = 64'h6c7967656e657261;
  localparam logic [63:0] IV3 = 64'h7465646279746573;

  localparam logic [7:0] WIDE_MARK       = 8'hee;  // lane 1 at start, lane 2 at final
  localparam logic [7:0] NARROW_MARK     = 8'hff;
  localparam logic [7:0] SECOND_WORD_MARK = 8'hdd;

  localparam logic [3:0] C_DEFAULT = 4'd2;
  localparam logic [3:0] D_DEFAULT = 4'd4;

  typedef struct packed {
    logic [63:0] v3;
    logic [63:0] v2;
    logic [63:0] v1;
    logic [63:0] v0;
  } lanes_t;

  // One half of a SipRound: two 64-bit adds side by side.
  function automatic lanes_t sip_half(input lanes_t l, input logic second);
    lanes_t      r;
    logic [63:0] a;
    logic [63:0] b;
    if (!second) begin
      a    = l.v0 + l.v1;
      b    = l.v2 + l.v3;
      r.v1 = {l.v1[50:0], l.v1[63:51]} ^ a;  // rotl 13
      r.v0 = {a[31:0], a[63:32]};            // rotl 32
      r.v3 = {l.v3[47:0], l.v3[63:48]} ^ b;  // rotl 16
      r.v2 = b;
    end else begin
      a    = l.v0 + l.v3;
      b    = l.v2 + l.v1;
      r.v3 = {l.v3[42:0], l.v3[63:43]} ^ a;  // rotl 21
      r.v0 = a;
      r.v1 = {l.v1[46:0], l.v1[63:47]} ^ b;  // rotl 17
      r.v2 = {b[31:0], b[63:32]};            // rotl 32
    end
    return r;
  endfunction

endpackage

// File: sv/siphash_keyed_hash.sv
// ----------------------------------------------------------------------------
// siphash_keyed_hash
// SipHash-c-d over a byte stream, one half round per cycle on a shared unit.
// ----------------------------------------------------------------------------
// A byte that does not complete a word is taken in S_IDLE. A byte that completes a word
//   runs c SipRounds in S_COMP (one half SipRound per cycle through the shared unit), then S_POST.
// End of message: compression of the padding word, then per digest word d SipRounds
//   in S_FIN and a hand-over in S_EMIT, which waits for the output register to drain.
// Synchronous active-low reset: idle, no open message, registers at defaults.
module siphash_keyed_hash
  import siphash_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] byte_present
  input  logic                 in_tlast,   // end_of_message
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [63:0] digest_word
  output logic                 out_tuser,  // [0] word_index
  output logic                 out_tlast,  // last_word
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // takes input items
  localparam logic [2:0] S_COMP = 3'd1;  // compression half rounds
  localparam logic [2:0] S_POST = 3'd2;  // fold message word into lane 0
  localparam logic [2:0] S_FIN  = 3'd3;  // finalization half rounds
  localparam logic [2:0] S_EMIT = 3'd4;  // hand digest word to output register

  logic [2:0]  state_r, state_nxt;

  // configuration registers
  logic [63:0] key_low_r, key_high_r;
  logic [3:0]  comp_rounds_r, fin_rounds_r;
  logic        wide_r;

  // hash context
  lanes_t      lanes_r, lanes_nxt;
  logic [63:0] msg_r, msg_nxt;          // word being compressed
  logic [55:0] part_r, part_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  len_r, len_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic        end_pend_r, end_pend_nxt; // finalize after current compression
  logic        pad_done_r, pad_done_nxt; // padding word already compressed
  logic        wide_fin_r, wide_fin_nxt; // wide mode sampled at finalization
  logic        word_idx_r, word_idx_nxt;
  logic [4:0]  rnd_r, rnd_nxt;           // half-round counter

  // output register
  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic        out_idx_r, out_last_r;

  // working values
  lanes_t      base_lanes;
  lanes_t      half_out;
  logic [55:0] base_part;
  logic [2:0]  base_cnt;
  logic [7:0]  base_len;
  logic [63:0] word_m;
  logic [63:0] pad_m;
  logic [3:0]  c_eff, d_eff, n_sel;
  logic        last_half;
  logic        out_free;
  logic        in_xfer;
  logic        do_item;
  logic [63:0] digest;

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_idx_r;
  assign out_tlast  = out_last_r;

  assign in_xfer  = in_tvalid && in_tready;
  assign do_item  = in_xfer && (in_tuser || in_tlast);
  assign out_free = !out_valid_r || out_tready;

  // zero round counts select the defaults
  assign c_eff = (comp_rounds_r == 4'd0) ? C_DEFAULT : comp_rounds_r;
  assign d_eff = (fin_rounds_r == 4'd0) ? D_DEFAULT : fin_rounds_r;
  assign n_sel = (state_r == S_FIN) ? d_eff : c_eff;
  assign last_half = (rnd_r == ({n_sel, 1'b0} - 5'd1));

  // the shared unit
  assign half_out = sip_half(lanes_r, rnd_r[0]);

  assign digest = lanes_r.v0 ^ lanes_r.v1 ^ lanes_r.v2 ^ lanes_r.v3;

  // context seen by an item: fresh key load when no message is open
  always_comb begin
    if (in_msg_r) begin
      base_lanes = lanes_r;
      base_part  = part_r;
      base_cnt   = cnt_r;
      base_len   = len_r;
    end else begin
      base_lanes.v0 = IV0 ^ key_low_r;
      base_lanes.v1 = IV1 ^ key_high_r ^ (wide_r ? {56'd0, WIDE_MARK} : 64'd0);
      base_lanes.v2 = IV2 ^ key_low_r;
      base_lanes.v3 = IV3 ^ key_high_r;
      base_part     = '0;
      base_cnt      = '0;
      base_len      = '0;
    end
  end

  assign word_m = {in_tdata, base_part};

  always_comb begin
    state_nxt    = state_r;
    lanes_nxt    = lanes_r;
    msg_nxt      = msg_r;
    part_nxt     = part_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    in_msg_nxt   = in_msg_r;
    end_pend_nxt = end_pend_r;
    pad_done_nxt = pad_done_r;
    wide_fin_nxt = wide_fin_r;
    word_idx_nxt = word_idx_r;
    rnd_nxt      = rnd_r;
    pad_m        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (do_item) begin
          lanes_nxt    = base_lanes;
          part_nxt     = base_part;
          cnt_nxt      = base_cnt;
          len_nxt      = base_len;
          in_msg_nxt   = 1'b1;
          rnd_nxt      = '0;
          end_pend_nxt = in_tlast;
          pad_done_nxt = 1'b0;
          if (in_tuser) begin
            len_nxt = base_len + 8'd1;
            if (base_cnt == 3'd7) begin
              // word complete: compress it, padding follows if this ends
              msg_nxt      = word_m;
              lanes_nxt.v3 = base_lanes.v3 ^ word_m;
              part_nxt     = '0;
              cnt_nxt      = '0;
              state_nxt    = S_COMP;
            end else begin
              part_nxt[{base_cnt, 3'b000} +: 8] = in_tdata;
              cnt_nxt = base_cnt + 3'd1;
            end
          end
          if (in_tlast && !(in_tuser && base_cnt == 3'd7)) begin
            pad_m        = {len_nxt, part_nxt};
            msg_nxt      = pad_m;
            lanes_nxt.v3 = base_lanes.v3 ^ pad_m;
            pad_done_nxt = 1'b1;
            state_nxt    = S_COMP;
          end
        end
      end

      S_COMP: begin
        lanes_nxt = half_out;
        rnd_nxt   = rnd_r + 5'd1;
        if (last_half) begin
          state_nxt = S_POST;
        end
      end

      S_POST: begin
        lanes_nxt.v0 = lanes_r.v0 ^ msg_r;
        rnd_nxt      = '0;
        if (!end_pend_r) begin
          state_nxt = S_IDLE;
        end else if (!pad_done_r) begin
          pad_m        = {len_r, part_r};
          msg_nxt      = pad_m;
          lanes_nxt.v3 = lanes_r.v3 ^ pad_m;
          pad_done_nxt = 1'b1;
          state_nxt    = S_COMP;
        end else begin
          lanes_nxt.v2 = lanes_r.v2 ^ {56'd0, (wide_r ? WIDE_MARK : NARROW_MARK)};
          wide_fin_nxt = wide_r;
          word_idx_nxt = 1'b0;
          state_nxt    = S_FIN;
        end
      end

      S_FIN: begin
        lanes_nxt = half_out;
        rnd_nxt   = rnd_r + 5'd1;
        if (last_half) begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          rnd_nxt = '0;
          if (wide_fin_r && !word_idx_r) begin
            lanes_nxt.v1 = lanes_r.v1 ^ {56'd0, SECOND_WORD_MARK};
            word_idx_nxt = 1'b1;
            state_nxt    = S_FIN;
          end else begin
            in_msg_nxt   = 1'b0;
            end_pend_nxt = 1'b0;
            part_nxt     = '0;
            cnt_nxt      = '0;
            len_nxt      = '0;
            state_nxt    = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control and context registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      part_r     <= '0;
      cnt_r      <= '0;
      len_r      <= '0;
      in_msg_r   <= 1'b0;
      end_pend_r <= 1'b0;
      pad_done_r <= 1'b0;
      wide_fin_r <= 1'b0;
      word_idx_r <= 1'b0;
      rnd_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      part_r     <= part_nxt;
      cnt_r      <= cnt_nxt;
      len_r      <= len_nxt;
      in_msg_r   <= in_msg_nxt;
      end_pend_r <= end_pend_nxt;
      pad_done_r <= pad_done_nxt;
      wide_fin_r <= wide_fin_nxt;
      word_idx_r <= word_idx_nxt;
      rnd_r      <= rnd_nxt;
    end
  end

  // lanes and message word: loaded before use, no reset
  always_ff @(posedge clk) begin
    lanes_r <= lanes_nxt;
    msg_r   <= msg_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r     <= '0;
      key_high_r    <= '0;
      comp_rounds_r <= C_DEFAULT;
      fin_rounds_r  <= D_DEFAULT;
      wide_r        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_LOW:     key_low_r     <= cfg_data;
        REG_KEY_HIGH:    key_high_r    <= cfg_data;
        REG_COMP_ROUNDS: comp_rounds_r <= cfg_data[3:0];
        REG_FIN_ROUNDS:  fin_rounds_r  <= cfg_data[3:0];
        REG_WIDE_OUTPUT: wide_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // output register: a digest word waits here while the core moves on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EMIT && out_free) begin
      out_data_r <= digest;
      out_idx_r  <= word_idx_r;
      out_last_r <= !wide_fin_r || word_idx_r;
    end
  end

endmodule
